// ===== design/mcdm_pkg.sv =====
`timescale 1ns / 1ps
package mcdm_pkg;

	localparam int GRID_SIDE    = 6;
	localparam int GRID_CELLS   = 36;
	localparam int CORR_W       = 6;
	localparam int SIZE_W       = 9;
	localparam int ID_W         = 8;
	localparam int DEPTH_DEFAULT = 256;
	localparam int NUM_ROT      = 4;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_MATCH = 1'b1;

	// Register indexes, taken from byte address bit 2.
	localparam logic REG_MAX_CORR  = 1'b0;
	localparam logic REG_DICT_SIZE = 1'b1;

	typedef logic [GRID_CELLS-1:0] grid_t;
	typedef logic [CORR_W-1:0]     dist_t;

	typedef struct packed {
		logic            operation;
		logic [ID_W-1:0] entry_index;
		grid_t           entry_code;
		grid_t           cell_bits;
	} item_t;

	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] marker_id;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Clockwise quarter turn: cell (r,c) moves to cell (c, 5-r).
	function automatic grid_t turn_grid(input grid_t g);
		grid_t res;
		int    src;
		int    dst;
		res = '0;
		for (int r = 0; r < GRID_SIDE; r++) begin
			for (int c = 0; c < GRID_SIDE; c++) begin
				src = r * GRID_SIDE + c;
				dst = c * GRID_SIDE + (GRID_SIDE - 1 - r);
				res[GRID_CELLS-1-dst] = g[GRID_CELLS-1-src];
			end
		end
		return res;
	endfunction

	function automatic dist_t count_ones(input grid_t v);
		dist_t n;
		n = '0;
		for (int i = 0; i < GRID_CELLS; i++) begin
			n = n + dist_t'(v[i]);
		end
		return n;
	endfunction

endpackage

// ===== design/mcdm_dict_mem.sv =====
`timescale 1ns / 1ps
module mcdm_dict_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  mcdm_pkg::grid_t       wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output mcdm_pkg::grid_t       rdata
);
	import mcdm_pkg::*;

	grid_t mem_q [DEPTH];
	grid_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mcdm_dist_unit.sv =====
`timescale 1ns / 1ps
module mcdm_dist_unit (
	input  mcdm_pkg::grid_t             grid,
	input  mcdm_pkg::grid_t             entry,
	input  mcdm_pkg::dist_t             max_corr,
	output logic [mcdm_pkg::NUM_ROT-1:0] hit
);
	import mcdm_pkg::*;

	grid_t rot [NUM_ROT];

	// The rotations are pure wiring; the four popcounts share one entry.
	assign rot[0] = grid;
	assign rot[1] = turn_grid(rot[0]);
	assign rot[2] = turn_grid(rot[1]);
	assign rot[3] = turn_grid(rot[2]);

	always_comb begin
		for (int r = 0; r < NUM_ROT; r++) begin
			hit[r] = (count_ones(rot[r] ^ entry) <= max_corr);
		end
	end

endmodule

// ===== design/marker_code_dictionary_match_unit.sv =====
`timescale 1ns / 1ps
// Dictionary lookup for 6x6 fiducial markers with Hamming-distance tolerance.
// A load transfer (operation 0) writes a 36-bit code into slot entry_index of
// an internal dictionary memory and produces no result; slots at or beyond
// DICT_DEPTH are ignored. A match transfer (operation 1) scans entries 0 to
// dictionary_size-1 (capped at DICT_DEPTH), reading one entry per cycle
// through the single read port of the memory and comparing it against all
// four clockwise rotations of cell_bits at once. The first hit in the lowest
// rotation wins, so the result is known only after the whole scan; item_stall
// is high from the match transfer until the result is loaded into the output
// register. If the previous result is still stalled in the output register
// when the scan ends, the block holds item_stall high until that result has
// been taken. The result sits in an output register, so the next item can be
// taken while it waits for result_stall to fall. The memory has no reset and
// needs no clearing pass; reading a slot that was never loaded gives an
// undefined code and so an undefined result. Configuration:
// max_correction_bits at byte address 0 and dictionary_size at byte address
// 4; write them only while the block is idle.
module marker_code_dictionary_match_unit #(
	parameter int DICT_DEPTH = mcdm_pkg::DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mcdm_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output mcdm_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mcdm_pkg::*;

	localparam int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
	localparam int CW = $clog2(DICT_DEPTH + 1);

	// Configuration registers.
	dist_t             max_corr_q;
	logic [SIZE_W-1:0] dict_size_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_corr_q  <= '0;
			dict_size_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MAX_CORR:  max_corr_q  <= pwdata[CORR_W-1:0];
				REG_DICT_SIZE: dict_size_q <= pwdata[SIZE_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_CORR:  prdata = 32'(max_corr_q);
			REG_DICT_SIZE: prdata = 32'(dict_size_q);
			default:       prdata = '0;
		endcase
	end

	// Number of entries to scan, capped at the memory depth.
	logic [CW-1:0] limit;

	always_comb begin
		if (32'(dict_size_q) > DICT_DEPTH) begin
			limit = CW'(DICT_DEPTH);
		end else begin
			limit = CW'(dict_size_q);
		end
	end

	// Sequencer.
	state_t         state_q;
	state_t         state_d;
	logic [CW-1:0]  cnt_q;
	logic           rd_en;
	logic           start;
	logic           load_wr;
	logic           out_load;
	logic           out_free;

	assign out_free = !result_valid || !result_stall;

	always_comb begin
		item_stall = 1'b1;
		rd_en      = 1'b0;
		start      = 1'b0;
		load_wr    = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				start      = item_valid && (item.operation == OP_MATCH);
				load_wr    = item_valid && (item.operation == OP_LOAD) &&
				             (32'(item.entry_index) < DICT_DEPTH);
			end
			ST_SCAN: begin
				rd_en = (cnt_q < limit);
			end
			ST_FINISH: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_SCAN;
			ST_SCAN:   if (!rd_en) state_d = ST_FINISH;
			ST_FINISH: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Grid under test, held for the whole scan.
	grid_t grid_q;

	always_ff @(posedge clk) begin
		if (start) begin
			grid_q <= item.cell_bits;
		end
	end

	// Dictionary memory; read data lines up with the _s1 stage.
	grid_t         entry_s1;
	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;

	mcdm_dict_mem #(
		.DEPTH (DICT_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (load_wr),
		.waddr (AW'(item.entry_index)),
		.wdata (item.entry_code),
		.re    (rd_en),
		.raddr (cnt_q[AW-1:0]),
		.rdata (entry_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[AW-1:0];
		end
	end

	// Shared compare unit: one entry against all four rotations.
	logic [NUM_ROT-1:0] hit;

	mcdm_dist_unit u_dist (
		.grid     (grid_q),
		.entry    (entry_s1),
		.max_corr (max_corr_q),
		.hit      (hit)
	);

	// First hit per rotation. Entries arrive in ascending order, so the first
	// one seen in a rotation is the lowest index for it.
	logic [NUM_ROT-1:0] rot_hit_q;
	logic [AW-1:0]      rot_id_q [NUM_ROT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_hit_q <= '0;
		end else if (start) begin
			rot_hit_q <= '0;
		end else if (rd_vld_s1) begin
			rot_hit_q <= rot_hit_q | hit;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_ROT; r++) begin
			if (rd_vld_s1 && hit[r] && !rot_hit_q[r]) begin
				rot_id_q[r] <= idx_s1;
			end
		end
	end

	// Lowest rotation with a hit wins.
	result_t res_d;

	always_comb begin
		res_d = '0;
		priority if (rot_hit_q[0]) begin
			res_d.found     = 1'b1;
			res_d.marker_id = ID_W'(rot_id_q[0]);
		end else if (rot_hit_q[1]) begin
			res_d.found     = 1'b1;
			res_d.marker_id = ID_W'(rot_id_q[1]);
		end else if (rot_hit_q[2]) begin
			res_d.found     = 1'b1;
			res_d.marker_id = ID_W'(rot_id_q[2]);
		end else if (rot_hit_q[3]) begin
			res_d.found     = 1'b1;
			res_d.marker_id = ID_W'(rot_id_q[3]);
		end else begin
			res_d = '0;
		end
	end

	// Output register.
	logic    result_valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= limit)
		else $error("scan counter passed the dictionary size");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == ST_SCAN)
		else $error("memory read outside a scan");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |-> !rd_vld_s1)
		else $error("result taken before the last entry was compared");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.marker_id == '0)
		else $error("marker_id nonzero without a match");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_wr |-> state_q == ST_IDLE && !item_stall)
		else $error("dictionary written during a scan");
`endif

endmodule
